@@ hw/rtl/css_pkg.sv @@
`default_nettype none
package css_pkg;

	localparam int MAX_SIDE    = 8;
	localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int SIZE_W      = 4;
	localparam int DIR_W       = 2;
	localparam int VALUE_W     = 8;
	localparam int COUNT_W     = 7;
	localparam int POS_W       = 5;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 4;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_BOARD_SIZE      = 1'b0,
		REG_START_DIRECTION = 1'b1
	} cfg_reg_t;

	typedef enum logic [DIR_W-1:0] {
		DIR_LEFT  = 2'd0,
		DIR_UP    = 2'd1,
		DIR_RIGHT = 2'd2,
		DIR_DOWN  = 2'd3
	} dir_t;

	typedef enum logic {
		ST_LOAD = 1'b0,
		ST_WALK = 1'b1
	} state_t;

endpackage
`default_nettype wire

@@ hw/rtl/center_spiral_scan_top.sv @@
// Loads an n by n byte matrix row-major, one element per request accepted while busy is low,
// into a 64-entry memory. The request that completes the matrix starts a spiral walk from the
// center cell; busy stays high during the walk. The walk reads one memory entry per cycle and
// each result appears in the cycle after its read as a single-cycle result_valid pulse, with
// last_of_walk set on the final one. The receiver cannot stall results, so it must take every
// pulse.
`default_nettype none
module center_spiral_scan_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic [css_pkg::VALUE_W-1:0]     element_value,
	output logic                                 result_valid,
	output logic      [css_pkg::VALUE_W-1:0]     visited_value,
	output logic                                 last_of_walk,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [css_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [css_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import css_pkg::*;

	logic [VALUE_W-1:0] mem [STORE_DEPTH];

	state_t              state_q, state_d;
	logic [SIZE_W-1:0]   board_size_q;
	logic [DIR_W-1:0]    start_dir_q;
	logic [COUNT_W-1:0]  load_count_q;
	logic signed [POS_W-1:0] row_q, col_q, row_n, col_n;
	logic [DIR_W-1:0]    dir_q, dir_n;
	logic [SIZE_W-1:0]   round_q, round_n;
	logic                half_q, half_n;
	logic [2:0]          k_q, k_n;

	logic [SIZE_W-1:0]   n_side;
	logic [COUNT_W-1:0]  total;
	logic [COUNT_W-1:0]  lc_eff, lc_inc;
	logic                accept, load_done, cfg_we, walk_end;
	logic [COUNT_W-1:0]  rd_prod;
	logic [ADDR_W-1:0]   rd_addr;
	logic signed [POS_W-1:0] n_signed;

	logic                valid_s1, last_s1;
	logic [VALUE_W-1:0]  data_s1;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign busy      = (state_q == ST_WALK);
	assign accept    = start && !busy;

	always_comb begin
		if (board_size_q == '0) begin
			n_side = SIZE_W'(1);
		end else if (board_size_q > SIZE_W'(MAX_SIDE)) begin
			n_side = SIZE_W'(MAX_SIDE);
		end else begin
			n_side = board_size_q;
		end
	end

	assign total     = {3'b000, n_side} * {3'b000, n_side};
	assign lc_eff    = (load_count_q >= total) ? '0 : load_count_q;
	assign lc_inc    = lc_eff + COUNT_W'(1);
	assign load_done = accept && (lc_inc == total);
	assign n_signed  = $signed({1'b0, n_side});

	assign rd_prod = {4'b0000, row_q[2:0]} * {3'b000, n_side} + {4'b0000, col_q[2:0]};
	assign rd_addr = rd_prod[ADDR_W-1:0];

	always_comb begin
		row_n = row_q;
		col_n = col_q;
		case (dir_t'(dir_q))
			DIR_LEFT:  col_n = col_q - POS_W'(1);
			DIR_UP:    row_n = row_q - POS_W'(1);
			DIR_RIGHT: col_n = col_q + POS_W'(1);
			DIR_DOWN:  row_n = row_q + POS_W'(1);
			default:   row_n = row_q;
		endcase
		dir_n   = dir_q;
		round_n = round_q;
		half_n  = half_q;
		k_n     = k_q + 3'd1;
		if ({1'b0, k_q} == round_q) begin
			k_n   = '0;
			dir_n = dir_q + DIR_W'(1);
			if (half_q) begin
				half_n  = 1'b0;
				round_n = round_q + SIZE_W'(1);
			end else begin
				half_n = 1'b1;
			end
		end
		walk_end = (row_n < 0) || (col_n < 0) || (row_n >= n_signed) ||
			(col_n >= n_signed) || (round_n == n_side);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (load_done) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (walk_end) begin
					state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			board_size_q <= SIZE_W'(5);
			start_dir_q  <= DIR_LEFT;
			load_count_q <= '0;
			valid_s1     <= 1'b0;
			last_s1      <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= busy;
			last_s1  <= busy && walk_end;
			if (cfg_we && cfg_index == REG_BOARD_SIZE) begin
				board_size_q <= cfg_data[SIZE_W-1:0];
				load_count_q <= '0;
			end else if (accept) begin
				load_count_q <= load_done ? '0 : lc_inc;
			end
			if (cfg_we && cfg_index == REG_START_DIRECTION) begin
				start_dir_q <= cfg_data[DIR_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_done) begin
			row_q   <= $signed({2'b00, n_side[3:1]});
			col_q   <= $signed({2'b00, n_side[3:1]});
			dir_q   <= start_dir_q;
			round_q <= '0;
			half_q  <= 1'b0;
			k_q     <= '0;
		end else if (busy) begin
			row_q   <= row_n;
			col_q   <= col_n;
			dir_q   <= dir_n;
			round_q <= round_n;
			half_q  <= half_n;
			k_q     <= k_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mem[lc_eff[ADDR_W-1:0]] <= element_value;
		end
	end

	always_ff @(posedge clk) begin
		if (busy) begin
			data_s1 <= mem[rd_addr];
		end
	end

	assign result_valid  = valid_s1;
	assign visited_value = data_s1;
	assign last_of_walk  = last_s1;

endmodule
`default_nettype wire

@@ bench/tb_center_spiral_scan_top.sv @@
`timescale 1ns / 100ps
module tb_center_spiral_scan_top;
	import css_pkg::*;

	localparam int LIMIT = 400000;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               last;
	} visit_t;

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   start         = 1'b0;
	logic [VALUE_W-1:0]     element_value = '0;
	logic                   cfg_valid     = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index     = '0;
	logic [CFG_DATA_W-1:0]  cfg_data      = '0;
	logic                   busy;
	logic                   result_valid;
	logic [VALUE_W-1:0]     visited_value;
	logic                   last_of_walk;
	logic                   cfg_ready;

	logic [VALUE_W-1:0] cells [STORE_DEPTH];
	int                 loaded   = 0;
	logic [SIZE_W-1:0]  size_reg = 4'd5;
	dir_t               dir_reg  = DIR_LEFT;

	logic [VALUE_W-1:0] pend_q [$];
	visit_t             visit_q [$];
	visit_t             want;
	int                 gap_left   = 0;
	bit                 calm       = 1'b0;
	int                 item_total = 0;
	int                 errors     = 0;
	int                 cycle_cnt  = 0;

	center_spiral_scan_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.element_value(element_value),
		.result_valid (result_valid),
		.visited_value(visited_value),
		.last_of_walk (last_of_walk),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #10 clk = ~clk;

	function automatic int side_of(logic [SIZE_W-1:0] s);
		if (s < 1)
			return 1;
		if (s > MAX_SIDE)
			return MAX_SIDE;
		return s;
	endfunction

	function automatic void trace_spiral(int n);
		int   r;
		int   c;
		int   count;
		bit   done;
		dir_t d;
		r     = n / 2;
		c     = n / 2;
		count = 0;
		done  = 1'b0;
		d     = dir_reg;
		for (int round = 0; round < n && !done; round++) begin
			for (int half = 0; half < 2 && !done; half++) begin
				for (int k = 0; k <= round && !done; k++) begin
					if (r < 0 || c < 0 || r >= n || c >= n || count >= STORE_DEPTH) begin
						done = 1'b1;
					end else begin
						visit_q.push_back('{value: cells[(r * n + c) % STORE_DEPTH], last: 1'b0});
						count++;
						case (d)
							DIR_LEFT:  c--;
							DIR_UP:    r--;
							DIR_RIGHT: c++;
							DIR_DOWN:  r++;
							default:   r = r;
						endcase
					end
				end
				d = dir_t'(d + 1'b1);
			end
		end
		if (count > 0)
			visit_q[$].last = 1'b1;
	endfunction

	function automatic void absorb_element(logic [VALUE_W-1:0] v);
		int n;
		int total;
		n     = side_of(size_reg);
		total = n * n;
		if (loaded >= total)
			loaded = 0;
		cells[loaded % STORE_DEPTH] = v;
		loaded++;
		if (loaded < total)
			return;
		loaded = 0;
		trace_spiral(n);
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				absorb_element(element_value);
			if (!(start && busy)) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (pend_q.size() > 0) begin
					element_value <= pend_q.pop_front();
					start <= 1'b1;
					if (!calm && $urandom_range(0, 2) == 0)
						gap_left = $urandom_range(1, 4);
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (visit_q.size() == 0) begin
				$error("visited_value: expected none, got %0d", visited_value);
				errors++;
			end else begin
				want = visit_q.pop_front();
				if (visited_value !== want.value) begin
					$error("visited_value: expected %0d, got %0d", want.value, visited_value);
					errors++;
				end
				if (last_of_walk !== want.last) begin
					$error("last_of_walk: expected %0d, got %0d", want.last, last_of_walk);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_BOARD_SIZE) begin
			size_reg = data;
			loaded   = 0;
		end else begin
			dir_reg = dir_t'(data[DIR_W-1:0]);
		end
	endtask

	task automatic settle();
		@(negedge clk);
		while (pend_q.size() != 0 || start || visit_q.size() != 0 || busy)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load(int cnt);
		repeat (cnt) pend_q.push_back(VALUE_W'($urandom_range(0, 255)));
		item_total += cnt;
		if (item_total >= 250)
			calm = 1'b1;
	endtask

	initial begin
		logic [SIZE_W-1:0] sz;
		int                side;
		int                pick;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A partial load at the reset size is dropped by the size write.
		pend_q.push_back(8'h01);
		pend_q.push_back(8'h02);
		pend_q.push_back(8'h04);
		settle();
		write_reg(REG_BOARD_SIZE, 4'd1);
		write_reg(REG_START_DIRECTION, {2'b00, DIR_LEFT});
		pend_q.push_back(8'h00);
		settle();
		write_reg(REG_START_DIRECTION, {2'b01, DIR_UP});
		pend_q.push_back(8'hFF);
		settle();
		write_reg(REG_START_DIRECTION, {2'b10, DIR_RIGHT});
		pend_q.push_back(8'h5A);
		settle();
		write_reg(REG_START_DIRECTION, {2'b11, DIR_DOWN});
		pend_q.push_back(8'hA5);
		settle();
		write_reg(REG_BOARD_SIZE, 4'd0);
		pend_q.push_back(8'h80);
		settle();
		write_reg(REG_BOARD_SIZE, 4'd2);
		write_reg(REG_START_DIRECTION, {2'b00, DIR_RIGHT});
		pend_q.push_back(8'h11);
		pend_q.push_back(8'h22);
		settle();
		write_reg(REG_BOARD_SIZE, 4'd2);
		pend_q.push_back(8'h7F);
		pend_q.push_back(8'h10);
		pend_q.push_back(8'h20);
		pend_q.push_back(8'h40);
		settle();
		write_reg(REG_BOARD_SIZE, 4'd3);
		write_reg(REG_START_DIRECTION, {2'b00, DIR_LEFT});
		pend_q.push_back(8'h00);
		pend_q.push_back(8'hFF);
		pend_q.push_back(8'h01);
		pend_q.push_back(8'hFE);
		settle();
		write_reg(REG_START_DIRECTION, {2'b00, DIR_DOWN});
		pend_q.push_back(8'h80);
		pend_q.push_back(8'h7F);
		pend_q.push_back(8'h33);
		pend_q.push_back(8'hCC);
		pend_q.push_back(8'h0F);
		settle();

		while (item_total < 300) begin
			pick = $urandom_range(0, 19);
			if (pick < 14)
				sz = SIZE_W'($urandom_range(1, 5));
			else if (pick < 17)
				sz = SIZE_W'($urandom_range(6, 8));
			else if (pick == 17)
				sz = '0;
			else
				sz = SIZE_W'($urandom_range(9, 15));
			side = side_of(sz);
			if ($urandom_range(0, 1)) begin
				write_reg(REG_BOARD_SIZE, sz);
				write_reg(REG_START_DIRECTION, CFG_DATA_W'($urandom_range(0, 15)));
			end else begin
				write_reg(REG_START_DIRECTION, CFG_DATA_W'($urandom_range(0, 15)));
				write_reg(REG_BOARD_SIZE, sz);
			end
			repeat ($urandom_range(1, 3)) begin
				if (side * side > 1 && $urandom_range(0, 7) == 0) begin
					load($urandom_range(1, side * side - 1));
					settle();
					if ($urandom_range(0, 1))
						write_reg(REG_BOARD_SIZE, sz);
					else
						write_reg(REG_START_DIRECTION, CFG_DATA_W'($urandom_range(0, 15)));
				end else begin
					load(side * side);
				end
			end
			settle();
		end

		settle();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/css_pkg.sv
hw/rtl/center_spiral_scan_top.sv
bench/tb_center_spiral_scan_top.sv
